/* hw/rtl/clps_pkg.sv */
// Package of the closest-lattice-point search unit: request and result
// types, command and status records, fixed-point widths and opcode names.
// No dependencies.
package clps_pkg;

    // Largest lattice dimension; the request and result index fields are sized for it.
    localparam int MAX_DIM = 8;

    // Fixed-point widths: Q8.16 values, Q20.32 squared distances.
    localparam int VAL_W  = 24;
    localparam int CRD_W  = 20;
    localparam int RES_W  = 16;
    localparam int RAD_W  = 52;
    localparam int STEP_W = 17;
    localparam int DIVD_W = 40;
    localparam int FRAC_W = 16;
    // Wide enough for every level and index of the largest supported dimension.
    localparam int LVL_W  = 5;

    localparam logic [RAD_W-1:0]  RAD_MAX     = {RAD_W{1'b1}};
    localparam logic [STEP_W-1:0] STEP_BUDGET = 17'd65536;

    localparam logic CFG_DIM = 1'b0;
    localparam logic CFG_RAD = 1'b1;

    localparam logic OP_GEN = 1'b0;
    localparam logic OP_TGT = 1'b1;

    // Datapath commands.
    localparam logic [4:0] DP_NOP   = 5'd0;
    localparam logic [4:0] DP_LOAD  = 5'd1;
    localparam logic [4:0] DP_START = 5'd2;
    localparam logic [4:0] DP_INIT  = 5'd3;
    localparam logic [4:0] DP_READ  = 5'd4;
    localparam logic [4:0] DP_MUL   = 5'd5;
    localparam logic [4:0] DP_PPWR  = 5'd6;
    localparam logic [4:0] DP_DIVGO = 5'd7;
    localparam logic [4:0] DP_CENT  = 5'd8;
    localparam logic [4:0] DP_RND   = 5'd9;
    localparam logic [4:0] DP_ZZ    = 5'd10;
    localparam logic [4:0] DP_T1    = 5'd11;
    localparam logic [4:0] DP_T2    = 5'd12;
    localparam logic [4:0] DP_T3    = 5'd13;
    localparam logic [4:0] DP_T4    = 5'd14;
    localparam logic [4:0] DP_UP    = 5'd15;
    localparam logic [4:0] DP_FIX   = 5'd16;
    localparam logic [4:0] DP_LEAF  = 5'd17;

    typedef struct packed {
        logic              op;
        logic [2:0]        row;
        logic [2:0]        col;
        logic signed [23:0] value;
        logic              last;
    } t_req;

    typedef struct packed {
        logic [2:0]         index;
        logic signed [15:0] coordinate;
        logic               found;
        logic               last_res;
    } t_res;

    typedef struct packed {
        logic [4:0]       op;
        logic [LVL_W-1:0] lvl;
        logic [LVL_W-1:0] row;
        logic [LVL_W-1:0] m;
    } t_cmd;

    typedef struct packed {
        logic               div_busy;
        logic               in_radius;
        logic [LVL_W-1:0]   n;
        logic [LVL_W-1:0]   rdepth;
        logic signed [15:0] coord;
        logic               found;
    } t_sts;

endpackage

/* hw/rtl/clps_divider.sv */
// Restoring divider of the search unit, one quotient bit per cycle.
// Depends on clps_pkg for its widths.
module clps_divider import clps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [VAL_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [VAL_W-1:0] r_dvs;
    logic [VAL_W:0]   shifted;
    logic [VAL_W:0]   diff;
    logic             take;

    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign take    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], take};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/clps_datapath.sv */
// Datapath of the search unit: matrix and projection memories, per-level
// registers, multipliers, the divider and the distance bookkeeping.
// Depends on clps_pkg and clps_divider.
module clps_datapath import clps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [RAD_W-1:0] i_cfg_data,
    input  t_req             i_req,
    input  t_cmd             i_cmd,
    output t_sts             o_sts
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LW    = $clog2(MAX_DIM + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 2 ** AW;
    localparam int EW    = VAL_W + CRD_W - 7;     // level error width
    localparam int TPW   = EW + VAL_W + 1;        // level error times diagonal
    localparam int QW    = TPW - FRAC_W;
    localparam int SQW   = RAD_W / 2;

    logic [3:0]       r_dim;
    logic [RAD_W-1:0] r_rad0;

    logic signed [VAL_W-1:0] r_gmem [DEPTH];
    logic signed [VAL_W-1:0] r_ppm  [DEPTH];
    logic signed [VAL_W-1:0] r_g_q;
    logic signed [VAL_W-1:0] r_pp_q;

    logic signed [VAL_W-1:0] r_tgt  [MAX_DIM];
    logic [IW-1:0]           r_rdep [MAX_DIM];
    logic [IW-1:0]           n_rdep [MAX_DIM];
    logic signed [CRD_W-1:0] r_tc   [MAX_DIM];
    logic signed [CRD_W-1:0] r_zz   [MAX_DIM];
    logic signed [CRD_W-1:0] r_best [MAX_DIM];
    logic signed [VAL_W-1:0] r_lc   [MAX_DIM];
    logic [VAL_W-1:0]        r_dg   [MAX_DIM];
    logic [RAD_W-1:0]        r_ld   [MAX_DIM + 1];
    logic [RAD_W-1:0]        r_rad;
    logic                    r_found;

    logic signed [VAL_W+CRD_W-1:0] r_prod;
    logic signed [VAL_W-1:0]       r_ppv;
    logic                          r_neg;
    logic signed [TPW-1:0]         r_tprod;
    logic [SQW-1:0]                r_q;
    logic                          r_qbig;
    logic [RAD_W-1:0]              r_term;

    logic [IW-1:0]      li, ri, mi, nm1;
    logic [LW-1:0]      ll, ll1, n_use;
    logic [AW-1:0]      rd_addr;
    logic signed [EW-1:0] err;
    logic [TPW-1:0]     tmag;
    logic [QW-1:0]      qfull;
    logic [VAL_W-1:0]   ppmag;
    logic [VAL_W-1:0]   diag;
    logic [RAD_W:0]     dsum;
    logic signed [VAL_W+CRD_W:0] ppdiff;
    logic               div_busy;
    logic [DIVD_W-1:0]  quo;
    logic               run;

    function automatic logic signed [VAL_W-1:0] sat24(input logic signed [VAL_W+CRD_W:0] v);
        if (v > (VAL_W+CRD_W+1)'(8388607)) return 24'sh7FFFFF;
        if (v < -(VAL_W+CRD_W+1)'(8388608)) return 24'sh800000;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [CRD_W-1:0] round_q16(input logic signed [VAL_W-1:0] p);
        logic [VAL_W:0] mag;
        mag = p[VAL_W-1] ? (VAL_W+1)'(-(VAL_W+1)'(p)) : (VAL_W+1)'(p);
        mag = mag + (VAL_W+1)'(32768);
        if (p[VAL_W-1]) return -CRD_W'(mag[VAL_W:FRAC_W]);
        return CRD_W'(mag[VAL_W:FRAC_W]);
    endfunction

    assign li  = IW'(i_cmd.lvl);
    assign ri  = IW'(i_cmd.row);
    assign mi  = IW'(i_cmd.m);
    assign ll  = LW'(i_cmd.lvl);
    assign ll1 = LW'(i_cmd.lvl + 1'b1);
    assign n_use = (r_dim == 4'd0) ? LW'(1) :
                   (int'(r_dim) > MAX_DIM) ? LW'(MAX_DIM) : LW'(r_dim);
    assign nm1 = IW'(n_use - 1'b1);
    assign rd_addr = {ri, li};

    // Error of the trial coordinate against the level centre, in Q.16.
    assign err   = EW'(r_lc[li]) - (EW'(r_tc[li]) <<< FRAC_W);
    assign tmag  = r_tprod[TPW-1] ? TPW'(-r_tprod) : TPW'(r_tprod);
    assign qfull = QW'((tmag + TPW'(32768)) >> FRAC_W);
    assign ppmag = r_pp_q[VAL_W-1] ? VAL_W'(-(VAL_W+1)'(r_pp_q)) : VAL_W'(r_pp_q);
    assign diag  = (r_g_q < 24'sd1) ? VAL_W'(1) : VAL_W'(r_g_q);
    assign dsum  = {1'b0, r_ld[ll1]} + {1'b0, r_term};
    assign ppdiff = (VAL_W+CRD_W+1)'(r_ppv) - (VAL_W+CRD_W+1)'(r_prod);

    clps_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == DP_DIVGO),
        .i_dividend ({ppmag, {FRAC_W{1'b0}}}),
        .i_divisor  (diag),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // Refresh-depth update after climbing: levels from m up to just below i take i,
    // and the run just below m takes i while its depths stay under i.
    always_comb begin
        run = 1'b1;
        for (int k = MAX_DIM - 1; k >= 0; k--) begin
            n_rdep[k] = r_rdep[k];
            if (k >= int'(mi) && k < int'(li)) begin
                n_rdep[k] = li;
            end else if (k < int'(mi)) begin
                run = run & (r_rdep[k] < li);
                if (run) n_rdep[k] = li;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= 4'd8;
            r_rad0  <= RAD_MAX;
            r_found <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIM: r_dim  <= i_cfg_data[3:0];
                    CFG_RAD: r_rad0 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == DP_START) r_found <= 1'b0;
            if (i_cmd.op == DP_LEAF)  r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_q  <= r_gmem[rd_addr];
        r_pp_q <= r_ppm[rd_addr];
        case (i_cmd.op)
            DP_LOAD: begin
                if (i_req.op == OP_GEN) begin
                    if (int'(i_req.row) < MAX_DIM && int'(i_req.col) < MAX_DIM)
                        r_gmem[{IW'(i_req.row), IW'(i_req.col)}] <= i_req.value;
                end else if (int'(i_req.row) < MAX_DIM) begin
                    r_tgt[IW'(i_req.row)] <= i_req.value;
                end
            end
            DP_START: begin
                r_ld[n_use] <= '0;
                r_rad       <= r_rad0;
            end
            DP_INIT: begin
                r_ppm[{nm1, ri}] <= r_tgt[ri];
                r_rdep[ri]       <= nm1;
                r_best[ri]       <= '0;
            end
            DP_MUL: begin
                r_prod <= (VAL_W+CRD_W)'(r_tc[ri]) * (VAL_W+CRD_W)'(r_g_q);
                r_ppv  <= r_pp_q;
            end
            DP_PPWR: r_ppm[{IW'(i_cmd.row - 1'b1), li}] <= sat24(ppdiff);
            DP_DIVGO: begin
                r_neg     <= r_pp_q[VAL_W-1];
                r_dg[li]  <= diag;
            end
            DP_CENT: begin
                if (r_neg)
                    r_lc[li] <= (quo > DIVD_W'(8388608)) ? 24'sh800000 : -VAL_W'(quo);
                else
                    r_lc[li] <= (quo > DIVD_W'(8388607)) ? 24'sh7FFFFF : VAL_W'(quo);
            end
            DP_RND: r_tc[li] <= round_q16(r_lc[li]);
            DP_ZZ:  r_zz[li] <= (err > 0) ? CRD_W'(1) : -CRD_W'(1);
            DP_T1:  r_tprod <= TPW'(err) * TPW'($signed({1'b0, r_dg[li]}));
            DP_T2: begin
                r_qbig <= |qfull[QW-1:SQW];
                r_q    <= qfull[SQW-1:0];
            end
            DP_T3: r_term <= r_qbig ? RAD_MAX : RAD_W'(r_q) * RAD_W'(r_q);
            DP_T4: r_ld[ll] <= dsum[RAD_W] ? RAD_MAX : dsum[RAD_W-1:0];
            DP_UP: begin
                r_tc[li] <= r_tc[li] + r_zz[li];
                r_zz[li] <= (r_zz[li] > 0) ? -r_zz[li] - CRD_W'(1) : -r_zz[li] + CRD_W'(1);
            end
            DP_FIX: begin
                for (int k = 0; k < MAX_DIM; k++) r_rdep[k] <= n_rdep[k];
            end
            DP_LEAF: begin
                for (int k = 0; k < MAX_DIM; k++) r_best[k] <= r_tc[k];
                r_rad <= r_ld[0];
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.div_busy  = div_busy;
        o_sts.in_radius = (!r_found && r_rad0 == RAD_MAX) || (r_ld[ll] < r_rad);
        o_sts.n         = LVL_W'(n_use);
        o_sts.rdepth    = LVL_W'(r_rdep[li]);
        if (r_best[ri] > CRD_W'(32767))       o_sts.coord = 16'sh7FFF;
        else if (r_best[ri] < -CRD_W'(32768)) o_sts.coord = 16'sh8000;
        else                                  o_sts.coord = r_best[ri][RES_W-1:0];
        o_sts.found     = r_found;
    end

endmodule

/* hw/rtl/clps_ctrl.sv */
// Controller of the search unit: request acceptance, the enumeration
// sequencer and the result register. Depends on clps_pkg.
module clps_ctrl import clps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_last,
    output logic o_req_stall,
    output logic o_res_valid,
    input  logic i_res_stall,
    output t_res o_res,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam int LW = $clog2(MAX_DIM + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_START = 5'd1;
    localparam logic [4:0] S_INIT  = 5'd2;
    localparam logic [4:0] S_DCHK  = 5'd3;
    localparam logic [4:0] S_RSET  = 5'd4;
    localparam logic [4:0] S_RRD   = 5'd5;
    localparam logic [4:0] S_RMUL  = 5'd6;
    localparam logic [4:0] S_RWR   = 5'd7;
    localparam logic [4:0] S_CRD   = 5'd8;
    localparam logic [4:0] S_CGO   = 5'd9;
    localparam logic [4:0] S_CWAIT = 5'd10;
    localparam logic [4:0] S_RND   = 5'd11;
    localparam logic [4:0] S_ZZ    = 5'd12;
    localparam logic [4:0] S_T1    = 5'd13;
    localparam logic [4:0] S_T2    = 5'd14;
    localparam logic [4:0] S_T3    = 5'd15;
    localparam logic [4:0] S_T4    = 5'd16;
    localparam logic [4:0] S_TEST  = 5'd17;
    localparam logic [4:0] S_UCHK  = 5'd18;
    localparam logic [4:0] S_FIX   = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;

    logic [4:0]        r_state, n_state;
    logic [LW-1:0]     r_lvl, n_lvl;
    logic [LW-1:0]     r_j, n_j;
    logic [LW-1:0]     r_m, n_m;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_up, n_up;
    logic              r_res_valid;
    t_res              r_res;
    logic              load_res;
    logic [LW-1:0]     n_dim;
    logic              out_end;

    assign n_dim   = LW'(i_sts.n);
    assign out_end = (r_j == n_dim - 1'b1);

    always_comb begin
        n_state  = r_state;
        n_lvl    = r_lvl;
        n_j      = r_j;
        n_m      = r_m;
        n_steps  = r_steps;
        n_up     = r_up;
        load_res = 1'b0;
        o_cmd.op  = DP_NOP;
        o_cmd.lvl = LVL_W'(r_lvl);
        o_cmd.row = LVL_W'(r_j);
        o_cmd.m   = LVL_W'(r_m);
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.op = DP_LOAD;
                    if (i_req_last) n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.op = DP_START;
                n_j      = '0;
                n_steps  = '0;
                n_lvl    = n_dim;
                n_up     = 1'b0;
                n_state  = S_INIT;
            end
            S_INIT: begin
                o_cmd.op = DP_INIT;
                if (out_end) n_state = S_DCHK;
                else         n_j = r_j + 1'b1;
            end
            S_DCHK: begin
                if (r_steps >= STEP_BUDGET) begin
                    n_j     = '0;
                    n_state = S_OUT;
                end else begin
                    n_steps = r_steps + 1'b1;
                    if (r_lvl != '0) begin
                        n_lvl   = r_lvl - 1'b1;
                        n_state = S_RSET;
                    end else begin
                        o_cmd.op = DP_LEAF;
                        n_state  = S_TEST;
                    end
                end
            end
            S_RSET: begin
                n_j     = LW'(i_sts.rdepth);
                n_state = S_RRD;
            end
            S_RRD: begin
                if (r_j > r_lvl) begin
                    o_cmd.op = DP_READ;
                    n_state  = S_RMUL;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_RMUL: begin
                o_cmd.op = DP_MUL;
                n_state  = S_RWR;
            end
            S_RWR: begin
                o_cmd.op = DP_PPWR;
                n_j      = r_j - 1'b1;
                n_state  = S_RRD;
            end
            S_CRD: begin
                o_cmd.op  = DP_READ;
                o_cmd.row = LVL_W'(r_lvl);
                n_state   = S_CGO;
            end
            S_CGO: begin
                o_cmd.op  = DP_DIVGO;
                o_cmd.row = LVL_W'(r_lvl);
                n_state   = S_CWAIT;
            end
            S_CWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = DP_CENT;
                    n_state  = S_RND;
                end
            end
            S_RND: begin
                o_cmd.op = DP_RND;
                n_state  = S_ZZ;
            end
            S_ZZ: begin
                o_cmd.op = DP_ZZ;
                n_state  = S_T1;
            end
            S_T1: begin
                o_cmd.op = DP_T1;
                n_state  = S_T2;
            end
            S_T2: begin
                o_cmd.op = DP_T2;
                n_state  = S_T3;
            end
            S_T3: begin
                o_cmd.op = DP_T3;
                n_state  = S_T4;
            end
            S_T4: begin
                o_cmd.op = DP_T4;
                n_state  = S_TEST;
            end
            S_TEST: begin
                if (!r_up) begin
                    if (i_sts.in_radius) begin
                        n_state = S_DCHK;
                    end else begin
                        n_m     = r_lvl;
                        n_state = S_UCHK;
                    end
                end else begin
                    n_state = i_sts.in_radius ? S_FIX : S_UCHK;
                end
            end
            S_UCHK: begin
                if (r_lvl == n_dim - 1'b1 || r_steps >= STEP_BUDGET) begin
                    n_j     = '0;
                    n_state = S_OUT;
                end else begin
                    n_steps   = r_steps + 1'b1;
                    n_lvl     = r_lvl + 1'b1;
                    o_cmd.lvl = LVL_W'(r_lvl + 1'b1);
                    o_cmd.op  = DP_UP;
                    n_up      = 1'b1;
                    n_state   = S_T1;
                end
            end
            S_FIX: begin
                o_cmd.op = DP_FIX;
                n_up     = 1'b0;
                n_state  = S_DCHK;
            end
            S_OUT: begin
                if (!r_res_valid || !i_res_stall) begin
                    load_res = 1'b1;
                    if (out_end) n_state = S_IDLE;
                    else         n_j = r_j + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_lvl       <= '0;
            r_j         <= '0;
            r_m         <= '0;
            r_steps     <= '0;
            r_up        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_j     <= n_j;
            r_m     <= n_m;
            r_steps <= n_steps;
            r_up    <= n_up;
            if (load_res)         r_res_valid <= 1'b1;
            else if (!i_res_stall) r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_res.index      <= 3'(r_j);
            r_res.coordinate <= i_sts.coord;
            r_res.found      <= i_sts.found;
            r_res.last_res   <= out_end;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* hw/rtl/closest_lattice_point_search_unit.sv */
// Top level of the closest-lattice-point search unit (Schnorr-Euchner order).
// Depends on clps_pkg, clps_ctrl and clps_datapath.
//
//  channel   direction  handshake                       payload
//  request   in         i_req_valid / o_req_stall       i_req (t_req)
//  result    out        o_res_valid / i_res_stall       o_res (t_res)
//  config    in         i_cfg_we, i_cfg_idx             i_cfg_data
//
// A load request is taken while the unit is idle. A request marked last then
// starts the search, during which further requests are stalled. The start
// initialises the per-level state for each dimension. A descending level visit
// refreshes the stale partial projections, waits on the bit-serial divider for
// the new centre and then adds the level's distance term; a climbing visit
// steps the zigzag and recomputes the distance term. The search is bounded by
// the 65536-visit step budget. The results then leave one per cycle through
// the output register as the far side takes them; stalling it holds the
// result in place. Reset is synchronous and active low and returns the
// configuration to eight dimensions and an unbounded radius.
module closest_lattice_point_search_unit import clps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  t_req             i_req,
    output logic             o_res_valid,
    input  logic             i_res_stall,
    output t_res             o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [RAD_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // The controller sequences the enumeration and owns the result register.
    clps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_last  (i_req.last),
        .o_req_stall (o_req_stall),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // The datapath holds all matrix, projection and per-level state.
    clps_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

/* hw/rtl/clps_checker.sv */
// Port-level checks for the search unit, bound to the top level.
// Depends on clps_pkg.
module clps_checker import clps_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input t_req i_req,
    input logic o_res_valid,
    input logic i_res_stall,
    input t_res o_res
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall && i_req.last |=> o_req_stall)
        else $error("request taken during search");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.found |-> o_res.coordinate == 16'sd0)
        else $error("coordinate set without a point found");

    a_gap_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_stall && o_res.last_res |=> !o_res_valid)
        else $error("result after the end of a run");

endmodule

bind closest_lattice_point_search_unit clps_checker u_chk (.*);

/* bench/closest_lattice_point_search_unit_test.sv */
// Self-checking bench for the closest-lattice-point search unit.
// It drives load requests, predicts each search result run in step with the
// requests and checks every result field. It depends on clps_pkg and the unit.
`timescale 1ns / 100ps

module closest_lattice_point_search_unit_test;
    import clps_pkg::*;

    localparam int          HALF_PERIOD = 10;
    localparam int          STALL_LIMIT = 20000000;
    localparam int          VISIT_LIMIT = 65536;
    localparam longint unsigned DIST_CAP = 64'h000F_FFFF_FFFF_FFFF;
    localparam int          Q_ONE = 65536;
    localparam int          REQUEST_TARGET = 200;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_req_valid = 1'b0;
    logic             o_req_stall;
    t_req             i_req = '0;
    logic             o_res_valid;
    logic             i_res_stall = 1'b0;
    t_res             o_res;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = CFG_DIM;
    logic [RAD_W-1:0] i_cfg_data = '0;

    closest_lattice_point_search_unit uut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // Mirror of the unit's configuration and search state.
    int unsigned     dim_reg;
    longint unsigned radius_reg;
    int              lat_gen[8][8];
    int              lat_tgt[8];
    int              proj[8][8];
    int              rdep[8];
    int              trial[8];
    int              zstep[8];
    longint unsigned ldist[9];
    int              lcent[8];
    int              best[8];
    longint unsigned radius;
    int              level;
    bit              hit;

    t_res coord_queue[$];
    int   mismatches = 0;
    int   sent = 0;
    int   quiet_cycles = 0;
    bit   calm = 1'b0;

    function automatic int sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return int'(v);
    endfunction

    function automatic longint diag(int i);
        return (lat_gen[i][i] < 1) ? 1 : lat_gen[i][i];
    endfunction

    // Round a Q8.16 value to the nearest integer, halves away from zero.
    function automatic int round_q16(int p);
        if (p >= 0) return int'((longint'(p) + 32768) >>> 16);
        return -int'(((-longint'(p)) + 32768) >>> 16);
    endfunction

    function automatic longint unsigned dist_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > DIST_CAP) ? DIST_CAP : s;
    endfunction

    function automatic longint unsigned level_cost(int i);
        longint          e;
        longint          prod;
        longint unsigned a;
        longint unsigned q;
        e = longint'(lcent[i]) - longint'(trial[i]) * Q_ONE;
        prod = e * diag(i);
        a = (prod < 0) ? longint'(-prod) : longint'(prod);
        q = (a + 32768) >> 16;
        if (q >= (64'd1 << 26)) return DIST_CAP;
        return q * q;
    endfunction

    function automatic bit within_radius(longint unsigned x);
        if (!hit && radius_reg == DIST_CAP) return 1'b1;
        return x < radius;
    endfunction

    // Depth-first zigzag enumeration, bounded by the visit budget.
    function automatic void run_search(int n);
        int unsigned visits;
        int          i;
        int          j;
        int          m;
        visits = 0;
        for (i = 0; i < n; i++) begin
            rdep[i] = n - 1;
            proj[n-1][i] = lat_tgt[i];
            best[i] = 0;
        end
        ldist[n] = 0;
        radius = radius_reg;
        hit = 1'b0;
        level = n;
        while (1) begin
            do begin
                if (visits >= VISIT_LIMIT) return;
                visits++;
                i = level;
                if (i != 0) begin
                    i--;
                    level = i;
                    for (j = rdep[i]; j > i; j--)
                        proj[j-1][i] = sat24(longint'(proj[j][i])
                            - longint'(trial[j]) * lat_gen[j][i]);
                    lcent[i] = sat24((longint'(proj[i][i]) * Q_ONE) / diag(i));
                    trial[i] = round_q16(lcent[i]);
                    zstep[i] = ((longint'(lcent[i]) - longint'(trial[i]) * Q_ONE) > 0)
                        ? 1 : -1;
                    ldist[i] = dist_add(ldist[i+1], level_cost(i));
                end else begin
                    for (j = 0; j < n; j++) best[j] = trial[j];
                    radius = ldist[0];
                    hit = 1'b1;
                end
            end while (within_radius(ldist[level]));

            m = level;
            do begin
                if (level == n - 1) return;
                if (visits >= VISIT_LIMIT) return;
                visits++;
                level++;
                i = level;
                trial[i] += zstep[i];
                zstep[i] = (zstep[i] > 0) ? -zstep[i] - 1 : -zstep[i] + 1;
                ldist[i] = dist_add(ldist[i+1], level_cost(i));
            end while (!within_radius(ldist[i]));

            i = level;
            for (j = m; j < i; j++) rdep[j] = i;
            for (j = m - 1; j >= 0; j--) begin
                if (rdep[j] < i) rdep[j] = i;
                else break;
            end
        end
    endfunction

    function automatic int dims_in_use();
        if (dim_reg < 1) return 1;
        if (dim_reg > 8) return 8;
        return dim_reg;
    endfunction

    // Apply one accepted request and queue the coordinates it produces.
    function automatic void apply_request(t_req r);
        int   n;
        int   c;
        t_res e;
        if (r.op == OP_GEN) lat_gen[r.row][r.col] = r.value;
        else lat_tgt[r.row] = r.value;
        if (!r.last) return;
        n = dims_in_use();
        run_search(n);
        for (int j = 0; j < n; j++) begin
            c = best[j];
            if (c > 32767) c = 32767;
            if (c < -32768) c = -32768;
            e.index = j[2:0];
            e.coordinate = c[15:0];
            e.found = hit;
            e.last_res = (j == n - 1);
            coord_queue.push_back(e);
        end
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 27);
    endfunction

    // Send one request; valid stays high into the next request unless a gap is drawn.
    task automatic send(bit op, int row, int col, int value, bit last);
        t_req r;
        r.op = op;
        r.row = row[2:0];
        r.col = col[2:0];
        r.value = value[23:0];
        r.last = last;
        @(negedge i_clk);
        while (idle_now()) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_req_stall);
        apply_request(r);
        sent++;
    endtask

    // Drop valid, wait for every queued coordinate and let the unit settle.
    task automatic drain();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        wait (coord_queue.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, longint unsigned data);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[RAD_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DIM) dim_reg = data[3:0];
        else radius_reg = data & DIST_CAP;
    endtask

    // One-dimensional corner cases: extreme targets, a non-positive diagonal,
    // a search started by a generator write, unused entries and a zero radius.
    task automatic test_directed();
        write_reg(CFG_DIM, 0);
        write_reg(CFG_RAD, DIST_CAP);
        send(OP_GEN, 0, 0, Q_ONE, 1'b0);
        send(OP_TGT, 0, 0, 8388607, 1'b1);
        send(OP_TGT, 0, 7, -8388608, 1'b1);
        send(OP_GEN, 0, 7, 8388607, 1'b0);
        send(OP_GEN, 3, 5, -8388608, 1'b0);
        send(OP_TGT, 5, 0, -8388608, 1'b0);
        send(OP_GEN, 0, 0, 0, 1'b0);
        send(OP_TGT, 0, 0, 70000, 1'b1);
        send(OP_GEN, 0, 0, -8388608, 1'b1);
        write_reg(CFG_DIM, 1);
        send(OP_GEN, 0, 0, 2 * Q_ONE, 1'b0);
        send(OP_TGT, 0, 0, -3 * Q_ONE - 32768, 1'b1);
        send(OP_TGT, 0, 0, 5 * Q_ONE + 32768, 1'b1);
        write_reg(CFG_RAD, 0);
        send(OP_TGT, 0, 0, 12345, 1'b1);
        write_reg(CFG_RAD, 64'd1 << 32);
        send(OP_TGT, 0, 0, 100000, 1'b1);
        send(OP_GEN, 0, 0, Q_ONE, 1'b1);
    endtask

    // Random well-conditioned problems with stray writes mixed in.
    task automatic test_random();
        int n;
        int pick;
        int problem;
        problem = 0;
        while (sent < REQUEST_TARGET) begin
            calm = (problem % 8) >= 5;
            if ($urandom_range(0, 99) < 40) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) write_reg(CFG_DIM, 0);
                else if (pick < 65) write_reg(CFG_DIM, $urandom_range(1, 3));
                else if (pick < 88) write_reg(CFG_DIM, $urandom_range(4, 7));
                else write_reg(CFG_DIM, $urandom_range(8, 15));
                pick = $urandom_range(0, 99);
                if (pick < 35) write_reg(CFG_RAD, DIST_CAP);
                else if (pick < 45) write_reg(CFG_RAD, 0);
                else if (pick < 55) write_reg(CFG_RAD, DIST_CAP - 1);
                else write_reg(CFG_RAD, (longint'($urandom_range(0, 16)) << 32)
                    | $urandom);
            end
            n = dims_in_use();
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c <= r; c++) begin
                    if ($urandom_range(0, 99) < 12) begin
                        if (n < 8 && $urandom_range(0, 1))
                            send(OP_TGT, $urandom_range(n, 7), $urandom_range(0, 7),
                                 int'($urandom), 1'b0);
                        else begin
                            pick = $urandom_range(0, 6);
                            send(OP_GEN, pick, $urandom_range(pick + 1, 7),
                                 int'($urandom), 1'b0);
                        end
                    end
                    if (c == r) send(OP_GEN, r, c, $urandom_range(32768, 131072), 1'b0);
                    else send(OP_GEN, r, c, int'($urandom_range(0, Q_ONE)) - 32768, 1'b0);
                end
            end
            // Now and then a load is abandoned; the next problem rewrites it all.
            if ($urandom_range(0, 99) < 10) begin
                problem++;
                continue;
            end
            for (int k = 0; k < n; k++)
                send(OP_TGT, k, $urandom_range(0, 7),
                     int'($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE,
                     (k == n - 1) && ($urandom_range(0, 99) >= 15));
            if (!i_req.last)
                send(OP_GEN, 0, 0, lat_gen[0][0], 1'b1);
            problem++;
        end
        calm = 1'b0;
    endtask

    // The result side stalls at random, except through the calm stretches.
    always @(negedge i_clk) begin
        i_res_stall <= idle_now();
    end

    // Every accepted result is checked against the oldest expected coordinate.
    always @(posedge i_clk) begin
        t_res want;
        if (o_res_valid && !i_res_stall) begin
            if (coord_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d coordinate %0d found %0b last %0b",
                             o_res.index, o_res.coordinate, o_res.found, o_res.last_res);
            end else begin
                want = coord_queue.pop_front();
                if (o_res.index !== want.index || o_res.coordinate !== want.coordinate ||
                    o_res.found !== want.found || o_res.last_res !== want.last_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 want.index, want.coordinate, want.found, want.last_res,
                                 o_res.index, o_res.coordinate, o_res.found,
                                 o_res.last_res);
                end
            end
        end
    end

    // Watchdog: a run of cycles with no handshake on either side means a hang.
    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_res_valid && !i_res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("closest_lattice_point_search_unit_test: FAIL");
            $finish;
        end
    end

    initial begin
        dim_reg = 8;
        radius_reg = DIST_CAP;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        drain();
        if (mismatches == 0 && coord_queue.size() == 0) begin
            $display("closest_lattice_point_search_unit_test: PASS");
        end else begin
            $display("closest_lattice_point_search_unit_test: FAIL");
        end
        $finish;
    end

endmodule
